/* rtl/core/coalescing_event_queue_core_defines.svh */
// ----------------------------------------------------------------------------
// Coalescing event queue assertion macros
// Shared concurrent assertion forms for the queue core RTL.
// ----------------------------------------------------------------------------
`ifndef COALESCING_EVENT_QUEUE_CORE_DEFINES_SVH
`define COALESCING_EVENT_QUEUE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define CEQ_ASSERT_SAME(lbl, clk, rst, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("assertion failed");
`define CEQ_ASSERT_NEXT(lbl, clk, rst, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("assertion failed");
`else
`define CEQ_ASSERT_SAME(lbl, clk, rst, ant, con)
`define CEQ_ASSERT_NEXT(lbl, clk, rst, ant, con)
`endif

`endif

/* rtl/core/ceq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coalescing event queue package
// Sizes and codes shared by the queue core and its testbench.
// ----------------------------------------------------------------------------
package ceq_pkg;

  localparam int ID_W       = 6;
  localparam int NUM_EVENTS = 1 << ID_W;
  localparam int CNT_W      = $clog2(NUM_EVENTS + 1);

  typedef enum logic [1:0] {
    OP_ACTIVATE = 2'd0,
    OP_TAKE     = 2'd1,
    OP_STOP     = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    RS_ACCEPTED   = 3'd0,
    RS_WAKE       = 3'd1,
    RS_DISPATCHED = 3'd2,
    RS_EMPTY      = 3'd3,
    RS_STOPPED    = 3'd4
  } res_status_t;

  typedef enum logic [1:0] {
    ES_IDLE   = 2'd0,
    ES_QUEUED = 2'd1,
    ES_AGAIN  = 2'd2
  } ev_status_t;

endpackage

/* rtl/core/ceq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue storage RAM
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module ceq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/coalescing_event_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coalescing event queue core
// Status table and circular id queue held in two RAMs with registered read ports.
// ----------------------------------------------------------------------------
// An activate goes through S_EXEC and a take on a non-empty queue through S_HEAD
// and then S_EXEC before the result is registered; other words are answered
// straight from S_IDLE when they are accepted.
// Busy holds off new words during an activate or a dispatch, which waits on the
// dependent reads of the queue RAM and then the status RAM; other words leave it idle.
// Synchronous reset empties the queue, clears the stop flag and marks every event
// idle at once; results cannot be stalled by the receiver.
`include "coalescing_event_queue_core_defines.svh"

module coalescing_event_queue_core
  import ceq_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      operation,
  input  logic [ID_W-1:0] event_id,
  output logic            done,
  output logic [2:0]      status,
  output logic [ID_W-1:0] event_id_res
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HEAD = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t             state;
  logic [1:0]         op_q;
  logic [ID_W-1:0]    id_q;
  logic [ID_W-1:0]    rd_ptr;
  logic [ID_W-1:0]    wr_ptr;
  logic [CNT_W-1:0]   count;
  logic               stop_req;
  logic [NUM_EVENTS-1:0] stat_valid;
  logic               stat_rvalid;

  logic [ID_W-1:0]    stat_raddr;
  logic [1:0]         stat_rdata;
  logic               stat_we;
  logic [1:0]         stat_wdata;
  logic [ID_W-1:0]    slot_rdata;
  logic               slot_we;
  logic [1:0]         cur_st;
  logic               accept;

  function automatic logic [ID_W-1:0] ptr_inc(input logic [ID_W-1:0] p);
    return (p == ID_W'(NUM_EVENTS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign stat_raddr = (state == S_HEAD) ? slot_rdata : event_id;
  assign cur_st     = stat_rvalid ? stat_rdata : ES_IDLE;

  ceq_ram #(.DEPTH(NUM_EVENTS), .WIDTH(2)) u_stat_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (id_q),
    .wdata (stat_wdata),
    .raddr (stat_raddr),
    .rdata (stat_rdata)
  );

  ceq_ram #(.DEPTH(NUM_EVENTS), .WIDTH(ID_W)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (wr_ptr),
    .wdata (id_q),
    .raddr (rd_ptr),
    .rdata (slot_rdata)
  );

  always_comb begin
    stat_we    = 1'b0;
    stat_wdata = ES_IDLE;
    slot_we    = 1'b0;
    if (state == S_EXEC) begin
      if (op_q == OP_ACTIVATE) begin
        case (cur_st)
          ES_IDLE: begin
            stat_we    = 1'b1;
            stat_wdata = ES_QUEUED;
            slot_we    = 1'b1;
          end
          ES_QUEUED: begin
            stat_we    = 1'b1;
            stat_wdata = ES_AGAIN;
          end
          default: begin
          end
        endcase
      end else begin
        case (cur_st)
          ES_IDLE: begin
          end
          ES_QUEUED: begin
            stat_we    = 1'b1;
            stat_wdata = ES_IDLE;
          end
          default: begin
            stat_we    = 1'b1;
            stat_wdata = ES_QUEUED;
            slot_we    = (count > CNT_W'(1));
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    stat_rvalid <= stat_valid[stat_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      count      <= '0;
      stop_req   <= 1'b0;
      stat_valid <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (stat_we) begin
        stat_valid[id_q] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q <= operation;
            id_q <= event_id;
            case (operation)
              OP_ACTIVATE: begin
                state <= S_EXEC;
              end
              OP_TAKE: begin
                if (count == '0) begin
                  done         <= 1'b1;
                  status       <= stop_req ? RS_STOPPED : RS_EMPTY;
                  event_id_res <= '0;
                end else begin
                  state <= S_HEAD;
                end
              end
              OP_STOP: begin
                stop_req     <= 1'b1;
                done         <= 1'b1;
                status       <= RS_ACCEPTED;
                event_id_res <= '0;
              end
              default: begin
                done         <= 1'b1;
                status       <= RS_ACCEPTED;
                event_id_res <= '0;
              end
            endcase
          end
        end
        S_HEAD: begin
          id_q  <= slot_rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_IDLE;
          done  <= 1'b1;
          if (op_q == OP_ACTIVATE) begin
            event_id_res <= '0;
            status       <= (cur_st == ES_IDLE && count == '0) ? RS_WAKE : RS_ACCEPTED;
            if (cur_st == ES_IDLE) begin
              wr_ptr <= ptr_inc(wr_ptr);
              count  <= count + 1'b1;
            end
          end else begin
            event_id_res <= id_q;
            status       <= RS_DISPATCHED;
            if (cur_st == ES_QUEUED) begin
              rd_ptr <= ptr_inc(rd_ptr);
              count  <= count - 1'b1;
            end else if (cur_st != ES_IDLE && count > CNT_W'(1)) begin
              rd_ptr <= ptr_inc(rd_ptr);
              wr_ptr <= ptr_inc(wr_ptr);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CEQ_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(NUM_EVENTS))
  `CEQ_ASSERT_SAME(a_empty_ptrs, clk, rst, count == '0, rd_ptr == wr_ptr)
  `CEQ_ASSERT_NEXT(a_exec_returns, clk, rst, state == S_EXEC, state == S_IDLE && done)
  `CEQ_ASSERT_NEXT(a_take_reads_head, clk, rst,
                   accept && operation == OP_TAKE && count != '0, state == S_HEAD)
  `CEQ_ASSERT_SAME(a_dispatch_source, clk, rst,
                   done && status == RS_DISPATCHED, $past(state == S_EXEC))

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coalescing event queue core testbench
// Drives activate, take, stop and unused-opcode words through the start/busy
// handshake in bursts with random gaps, mirrors the event status table and
// the id queue in a local scheduler copy, and checks every strobed result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import ceq_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         RANDOM_WORDS = 950;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [1:0]      op;
    logic [ID_W-1:0] id;
  } word_t;

  typedef struct packed {
    res_status_t     status;
    logic [ID_W-1:0] id;
  } outcome_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic [1:0]      operation = '0;
  logic [ID_W-1:0] event_id = '0;
  logic            busy;
  logic            done;
  logic [2:0]      status;
  logic [ID_W-1:0] event_id_res;

  word_t    pending_words[$];
  outcome_t expected_outcomes[$];

  ev_status_t      sched_state[NUM_EVENTS];
  logic [ID_W-1:0] sched_slots[NUM_EVENTS];
  logic [ID_W-1:0] sched_rd;
  logic [ID_W-1:0] sched_wr;
  logic [CNT_W-1:0] sched_depth;
  logic            sched_stop;
  int              deepest_queue = 0;

  int errors = 0;
  int words_sent = 0;
  int words_queued = 0;
  int status_tally[0:4] = '{default: 0};
  int gap_left = 0;
  int burst_left = 0;
  int quiet_cycles = 0;

  coalescing_event_queue_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .event_id     (event_id),
    .done         (done),
    .status       (status),
    .event_id_res (event_id_res)
  );

  always #6 clk = ~clk;

  // Scheduler copy: applies one accepted word and returns the result it causes.
  function automatic void schedule_word(input logic [1:0] op, input logic [ID_W-1:0] id,
                                        output res_status_t st, output logic [ID_W-1:0] rid);
    logic [ID_W-1:0] head;
    st  = RS_ACCEPTED;
    rid = '0;
    case (op)
      OP_ACTIVATE: begin
        if (sched_state[id] == ES_IDLE) begin
          sched_state[id] = ES_QUEUED;
          if (sched_depth == 0) st = RS_WAKE;
          sched_slots[sched_wr] = id;
          sched_wr = sched_wr + 1'b1;
          sched_depth = sched_depth + 1'b1;
          if (sched_depth > deepest_queue) deepest_queue = sched_depth;
        end else if (sched_state[id] == ES_QUEUED) begin
          sched_state[id] = ES_AGAIN;
        end
      end
      OP_TAKE: begin
        if (sched_depth == 0) begin
          st = sched_stop ? RS_STOPPED : RS_EMPTY;
        end else begin
          head = sched_slots[sched_rd];
          st   = RS_DISPATCHED;
          rid  = head;
          if (sched_state[head] == ES_QUEUED) begin
            sched_state[head] = ES_IDLE;
            sched_rd = sched_rd + 1'b1;
            sched_depth = sched_depth - 1'b1;
          end else if (sched_state[head] != ES_IDLE) begin
            sched_state[head] = ES_QUEUED;
            if (sched_depth > 1) begin
              sched_rd = sched_rd + 1'b1;
              sched_slots[sched_wr] = head;
              sched_wr = sched_wr + 1'b1;
            end
          end
        end
      end
      OP_STOP: sched_stop = 1'b1;
      default: ;
    endcase
  endfunction

  task automatic add_word(input logic [1:0] op, input logic [ID_W-1:0] id);
    pending_words.push_back('{op: op, id: id});
    if (op != OP_UNUSED) words_queued++;
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 3) == 0) return ID_W'($urandom_range(0, 7));
    return ID_W'($urandom_range(0, NUM_EVENTS - 1));
  endfunction

  always @(posedge clk) begin : drive_words
    word_t           w;
    res_status_t     st;
    logic [ID_W-1:0] rid;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        schedule_word(operation, event_id, st, rid);
        expected_outcomes.push_back('{status: st, id: rid});
        words_sent++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          start     <= 1'b1;
          operation <= w.op;
          event_id  <= w.id;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result, status %0d id %0d", $time, status, event_id_res);
        errors++;
      end else begin
        want = expected_outcomes.pop_front();
        if (status !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.status, status);
          errors++;
        end
        if (event_id_res !== want.id) begin
          $display("%0t: event_id_res mismatch, expected %0d actual %0d",
                   $time, want.id, event_id_res);
          errors++;
        end
        status_tally[want.status]++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int              phase;
    int              n;
    int              r;
    int              j;
    logic [ID_W-1:0] order[NUM_EVENTS];
    logic [ID_W-1:0] t;

    foreach (sched_state[i]) sched_state[i] = ES_IDLE;
    foreach (sched_slots[i]) sched_slots[i] = '0;
    sched_rd    = '0;
    sched_wr    = '0;
    sched_depth = '0;
    sched_stop  = 1'b0;

    // Directed opening: empty take, wake, coalescing, lone requeue, move to tail,
    // ignored id on take, unused opcode, stop and stopped takes.
    add_word(OP_TAKE, 6'd0);
    add_word(OP_ACTIVATE, 6'd0);
    add_word(OP_ACTIVATE, 6'd0);
    add_word(OP_ACTIVATE, 6'd0);
    add_word(OP_TAKE, 6'd63);
    add_word(OP_TAKE, 6'd0);
    add_word(OP_TAKE, 6'd0);
    add_word(OP_ACTIVATE, 6'd63);
    add_word(OP_ACTIVATE, 6'd42);
    add_word(OP_ACTIVATE, 6'd63);
    add_word(OP_ACTIVATE, 6'd21);
    add_word(OP_TAKE, 6'd0);
    add_word(OP_TAKE, 6'd0);
    add_word(OP_TAKE, 6'd0);
    add_word(OP_TAKE, 6'd0);
    add_word(OP_TAKE, 6'd63);
    add_word(OP_UNUSED, 6'd63);
    add_word(OP_STOP, 6'd21);
    add_word(OP_TAKE, 6'd42);
    add_word(OP_ACTIVATE, 6'd5);
    add_word(OP_TAKE, 6'd0);
    add_word(OP_TAKE, 6'd0);

    while (words_queued < RANDOM_WORDS) begin
      phase = $urandom_range(0, 9);
      if (phase <= 2) begin
        n = $urandom_range(4, 40);
        repeat (n) add_word(OP_ACTIVATE, pick_id());
      end else if (phase <= 5) begin
        n = $urandom_range(4, 48);
        repeat (n) add_word(OP_TAKE, ID_W'($urandom));
      end else if (phase <= 8) begin
        n = $urandom_range(8, 30);
        repeat (n) begin
          r = $urandom_range(0, 19);
          if (r < 9)       add_word(OP_ACTIVATE, pick_id());
          else if (r < 18) add_word(OP_TAKE, ID_W'($urandom));
          else if (r < 19) add_word(OP_STOP, ID_W'($urandom));
          else             add_word(OP_UNUSED, ID_W'($urandom));
        end
      end else begin
        // Fill every id in shuffled order, requeue some, then drain past empty.
        foreach (order[i]) order[i] = ID_W'(i);
        for (int i = NUM_EVENTS - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = order[i];
          order[i] = order[j];
          order[j] = t;
        end
        foreach (order[i]) add_word(OP_ACTIVATE, order[i]);
        repeat (16) add_word(OP_ACTIVATE, ID_W'($urandom));
        repeat (NUM_EVENTS + 24) add_word(OP_TAKE, ID_W'($urandom));
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() > 0 || start) @(posedge clk);
    while (expected_outcomes.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_outcomes.size() != 0) begin
      $display("%0t: results missing, expected %0d more actual 0",
               $time, expected_outcomes.size());
      errors++;
    end

    $display("Sent %0d words; results: %0d accepted, %0d wake, %0d dispatched,",
             words_sent, status_tally[RS_ACCEPTED], status_tally[RS_WAKE],
             status_tally[RS_DISPATCHED]);
    $display("%0d empty, %0d stopped; deepest queue %0d of %0d ids.",
             status_tally[RS_EMPTY], status_tally[RS_STOPPED], deepest_queue, NUM_EVENTS);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
